// ===== sv/sketch_index_to_kmer_decoder_defines.svh =====
// assertion macros for the sketch index to k-mer decoder
`ifndef SKETCH_INDEX_TO_KMER_DECODER_DEFINES_SVH
`define SKETCH_INDEX_TO_KMER_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

`define SIKD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define SIKD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SIKD_ASSERT_SAME(label, clk, rst, ante, cons)

`define SIKD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/sikd_pkg.sv =====
// shared constants and types of the sketch index to k-mer decoder
package sikd_pkg;

   localparam int TABLE_DEPTH      = 4096;
   localparam int POSITION_WIDTH   = 28;
   localparam int TABLE_ADDR_WIDTH = $clog2(TABLE_DEPTH);

   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH   = 6;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CODE_SHIFT      = 3'd0,
      CSR_PREFIX_BITS     = 3'd1,
      CSR_INNER_BITS      = 3'd2,
      CSR_HALF_OUTER_BITS = 3'd3,
      CSR_HALF_LENGTH     = 3'd4
   } csr_index_type;

   typedef enum logic {
      FUNC_LOAD   = 1'b0,
      FUNC_DECODE = 1'b1
   } func_type;

endpackage

// ===== sv/sikd_req_if.sv =====
// request channel interface of the sketch index to k-mer decoder
interface sikd_req_if import sikd_pkg::*; ();

   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [POSITION_WIDTH-1:0] position;
   logic [31:0]               dim_value;
   logic [31:0]               sketch_index;
   logic [15:0]               component_id;

   modport source (output valid, func, position, dim_value, sketch_index, component_id,
                   input ready);
   modport sink   (input valid, func, position, dim_value, sketch_index, component_id,
                   output ready);

endinterface

// ===== sv/sikd_rsp_if.sv =====
// response channel interface of the sketch index to k-mer decoder
interface sikd_rsp_if import sikd_pkg::*; ();

   logic        valid;
   logic        ready;
   logic [63:0] unituple;
   logic [1:0]  base_code;
   logic        last;

   modport source (output valid, unituple, base_code, last, input ready);
   modport sink   (input valid, unituple, base_code, last, output ready);

endinterface

// ===== sv/sketch_index_to_kmer_decoder.sv =====
// Sketch index to k-mer decoder. A load transaction (func 0) writes the position into the
// inverse shuffle table at dim_value when dim_value is below the table depth. A decode
// transaction (func 1) forms (sketch_index << code_shift) + component_id, reads the table at
// its low bits, rebuilds and reorders the tuple over two register stages, and then returns 2k
// response transactions, one per cycle while rsp ready is high, k being half_length clamped
// to 1..16. The decode passes the table read register and s2_tuple_ff before its first
// response leaves uni_ff. The output serializer sends one base per cycle while rsp ready is
// high; loads and the next decodes keep entering while a run drains until stages 1 and 2
// each hold a waiting decode, and then all requests are held off. The table comes up
// unwritten and needs no clearing pass; decode only indexes that were loaded.
`include "sketch_index_to_kmer_decoder_defines.svh"

module sketch_index_to_kmer_decoder import sikd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   sikd_req_if.sink                   req_bus,
   sikd_rsp_if.source                 rsp_bus,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [5:0] code_shift_ff, code_shift_in;
   logic [5:0] prefix_bits_ff, prefix_bits_in;
   logic [5:0] inner_bits_ff, inner_bits_in;
   logic [5:0] half_outer_bits_ff, half_outer_bits_in;
   logic [4:0] half_length_ff, half_length_in;

   logic                        req_accept;
   logic                        is_decode;
   logic                        tbl_we;
   logic                        tbl_re;
   logic [63:0]                 reduced;
   logic [POSITION_WIDTH-1:0]   tbl_rdata;

   logic        s1_valid_ff, s1_valid_in;
   logic [63:0] s1_reduced_ff, s1_reduced_in;
   logic        s1_ready;
   logic        s1_move;

   logic        s2_valid_ff, s2_valid_in;
   logic [63:0] s2_tuple_ff, s2_tuple_in;
   logic        s2_ready;
   logic        s2_move;

   logic        busy_ff, busy_in;
   logic [63:0] uni_ff, uni_in;
   logic [4:0]  rem_ff, rem_in;
   logic        s3_ready;
   logic        rsp_accept;

   logic [63:0] half_mask;
   logic [63:0] inner_mask;
   logic [3:0]  k_m1;

   // configuration registers
   always_comb begin
      code_shift_in      = code_shift_ff;
      prefix_bits_in     = prefix_bits_ff;
      inner_bits_in      = inner_bits_ff;
      half_outer_bits_in = half_outer_bits_ff;
      half_length_in     = half_length_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CODE_SHIFT:      code_shift_in      = csr_wdata;
            CSR_PREFIX_BITS:     prefix_bits_in     = csr_wdata;
            CSR_INNER_BITS:      inner_bits_in      = csr_wdata;
            CSR_HALF_OUTER_BITS: half_outer_bits_in = csr_wdata;
            CSR_HALF_LENGTH:     half_length_in     = csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // stage 0: table write or read
   assign req_accept = req_bus.valid && req_bus.ready;
   assign is_decode  = req_bus.func == FUNC_DECODE;
   assign tbl_we     = req_accept && !is_decode && (req_bus.dim_value < 32'(TABLE_DEPTH));
   assign tbl_re     = req_accept && is_decode;
   assign reduced    = (64'(req_bus.sketch_index) << code_shift_ff)
                       + 64'(req_bus.component_id);

   sikd_ram #(
      .WIDTH (POSITION_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (req_bus.dim_value[TABLE_ADDR_WIDTH-1:0]),
      .wr_data (req_bus.position),
      .rd_en   (tbl_re),
      .rd_addr (reduced[TABLE_ADDR_WIDTH-1:0]),
      .rd_data (tbl_rdata)
   );

   assign s1_ready      = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;

   always_comb begin
      s1_valid_in   = s1_ready ? tbl_re : s1_valid_ff;
      s1_reduced_in = tbl_re ? reduced : s1_reduced_ff;
   end

   // stage 1: rebuild tuple
   assign s1_move  = s1_valid_ff && s2_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;

   always_comb begin
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      s2_tuple_in = s2_tuple_ff;
      if (s1_move) begin
         s2_tuple_in = ((s1_reduced_ff >> prefix_bits_ff) << inner_bits_ff)
                       + 64'(tbl_rdata);
      end
   end

   // stage 2: swap inner and lower half-outer fields, load serializer
   assign s2_move    = s2_valid_ff && s3_ready;
   assign half_mask  = ((64'd1 << half_outer_bits_ff) - 64'd1) << inner_bits_ff;
   assign inner_mask = (64'd1 << inner_bits_ff) - 64'd1;

   always_comb begin
      if (half_length_ff == 5'd0) begin
         k_m1 = 4'd0;
      end else if (half_length_ff > 5'd16) begin
         k_m1 = 4'd15;
      end else begin
         k_m1 = 4'(half_length_ff - 5'd1);
      end
   end

   assign rsp_accept = rsp_bus.valid && rsp_bus.ready;
   assign s3_ready   = !busy_ff || (rsp_accept && rem_ff == 5'd0);

   always_comb begin
      busy_in = busy_ff;
      uni_in  = uni_ff;
      rem_in  = rem_ff;
      if (rsp_accept) begin
         rem_in = rem_ff - 5'd1;
         if (rem_ff == 5'd0) begin
            busy_in = 1'b0;
         end
      end
      if (s2_move) begin
         busy_in = 1'b1;
         rem_in  = {k_m1, 1'b1};
         uni_in  = (s2_tuple_ff & (half_mask << half_outer_bits_ff))
                   + ((s2_tuple_ff & half_mask) >> inner_bits_ff)
                   + ((s2_tuple_ff & inner_mask) << half_outer_bits_ff);
      end
   end

   assign rsp_bus.valid     = busy_ff;
   assign rsp_bus.unituple  = uni_ff;
   assign rsp_bus.base_code = 2'(uni_ff >> {rem_ff, 1'b0});
   assign rsp_bus.last      = rem_ff == 5'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_shift_ff      <= 6'd0;
         prefix_bits_ff     <= 6'd12;
         inner_bits_ff      <= 6'd24;
         half_outer_bits_ff <= 6'd20;
         half_length_ff     <= 5'd16;
         s1_valid_ff        <= 1'b0;
         s2_valid_ff        <= 1'b0;
         busy_ff            <= 1'b0;
         rem_ff             <= 5'd0;
      end else begin
         code_shift_ff      <= code_shift_in;
         prefix_bits_ff     <= prefix_bits_in;
         inner_bits_ff      <= inner_bits_in;
         half_outer_bits_ff <= half_outer_bits_in;
         half_length_ff     <= half_length_in;
         s1_valid_ff        <= s1_valid_in;
         s2_valid_ff        <= s2_valid_in;
         busy_ff            <= busy_in;
         rem_ff             <= rem_in;
      end
      s1_reduced_ff <= s1_reduced_in;
      s2_tuple_ff   <= s2_tuple_in;
      uni_ff        <= uni_in;
   end

   `SIKD_ASSERT_NEXT(a_decode_enters, clock, reset, tbl_re, s1_valid_ff)
   `SIKD_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !s2_ready,
                     s1_valid_ff && $stable(s1_reduced_ff) && $stable(tbl_rdata))
   `SIKD_ASSERT_NEXT(a_run_continues, clock, reset, rsp_accept && rem_ff != 5'd0,
                     busy_ff && $stable(uni_ff))
   `SIKD_ASSERT_SAME(a_no_read_on_load, clock, reset, tbl_we, !tbl_re)

endmodule

// ===== sv/sikd_ram.sv =====
// generic single-port-write ram with registered read
module sikd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
